>>> sv/tsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    localparam int QUEUE_W      = 2;
    localparam int TENANT_W     = 8;
    localparam int LEN_W        = 16;
    localparam int CYC_W        = 32;
    localparam int CNT_W        = 7;
    localparam int BYTES_W      = 22;
    localparam int SLOT_BYTES_W = 23;
    localparam int ACT_W        = 9;
    localparam int PPW_W        = 16;
    localparam int FLUSH_BATCH  = 64;

    localparam logic [ACT_W-1:0] ACTIVE_TENANTS_RST     = 9'd256;
    localparam logic [PPW_W-1:0] PACKETS_PER_WAKEUP_RST = 16'd64;

    // register index = paddr[2]
    localparam logic CFG_ACTIVE_TENANTS     = 1'b0;
    localparam logic CFG_PACKETS_PER_WAKEUP = 1'b1;

    localparam logic CMD_DRAIN = 1'b1;

    localparam logic KIND_CONSUME = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } t_ctrl_state;

    typedef enum logic [1:0] {
        SEL_CHG,
        SEL_CONS,
        SEL_BATCH,
        SEL_DRAIN
    } t_emit_sel;

    typedef struct packed {
        logic      capture;
        logic      update;
        logic      emit;
        t_emit_sel sel;
        logic      scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic pend_chg;
        logic pend_cons;
        logic pend_batch;
        logic pend_drain;
        logic cur_flush;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/tenant_stats_coalescer_core.sv
// Per-tenant packet statistics coalescer.
// Input channel (i_valid/o_ready): one transaction per packet-done event or
// drain command. Output channel (o_valid/i_ready): zero or more records per transaction,
// o_last set on the final record that an input transaction causes; a
// transaction that causes no record produces nothing on the output.
// Timing: one transaction is worked at a time. A packet event is captured,
// then its slot is updated, then its tenant-change, consumption and batch
// records go out in that order before the next transaction is accepted.
// A drain (command or automatic) walks the slots one per cycle through a
// single slot port while the output register is free, its flush records
// going out in step; slots with nothing to flush do not wait on the output.
// Records leave through one output register. When the receiver stalls, the
// sequencer holds at the next record until that register frees; the next
// input transaction is accepted while the final record still waits.
// Registers on the APB port: 0x0 active_tenants (9 bits, reset 256),
// 0x4 packets_per_wakeup (16 bits, reset 64). Write them only while idle.
// Reset (synchronous, active low) empties all slots, zeroes the packet
// counter and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module tenant_stats_coalescer_core #(
    parameter int QUEUES = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_cmd,
    input  wire logic [tsc_pkg::QUEUE_W-1:0]   i_queue,
    input  wire logic [tsc_pkg::TENANT_W-1:0]  i_tenant,
    input  wire logic                          i_was_forwarded,
    input  wire logic [tsc_pkg::LEN_W-1:0]     i_packet_length,
    input  wire logic [tsc_pkg::CYC_W-1:0]     i_cycles_spent,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_record_kind,
    output logic [tsc_pkg::TENANT_W-1:0]       o_record_tenant,
    output logic [tsc_pkg::CNT_W-1:0]          o_forwarded_count,
    output logic [tsc_pkg::CNT_W-1:0]          o_dropped_count,
    output logic [tsc_pkg::BYTES_W-1:0]        o_byte_count,
    output logic [tsc_pkg::CYC_W-1:0]          o_cycle_count,
    output logic                               o_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tsc_pkg::*;

    logic [ACT_W-1:0] r_active_tenants;
    logic [PPW_W-1:0] r_packets_per_wakeup;
    logic             cfg_write;
    t_dp_cmd          w_ctl;
    t_dp_stat         w_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_tenants     <= ACTIVE_TENANTS_RST;
            r_packets_per_wakeup <= PACKETS_PER_WAKEUP_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                CFG_ACTIVE_TENANTS:     r_active_tenants     <= pwdata[ACT_W-1:0];
                CFG_PACKETS_PER_WAKEUP: r_packets_per_wakeup <= pwdata[PPW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_ACTIVE_TENANTS:     prdata = 32'(r_active_tenants);
            CFG_PACKETS_PER_WAKEUP: prdata = 32'(r_packets_per_wakeup);
        endcase
    end

    tsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    tsc_datapath #(
        .QUEUES (QUEUES)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (w_ctl),
        .o_stat               (w_stat),
        .i_cmd                (i_cmd),
        .i_queue              (i_queue),
        .i_tenant             (i_tenant),
        .i_was_forwarded      (i_was_forwarded),
        .i_packet_length      (i_packet_length),
        .i_cycles_spent       (i_cycles_spent),
        .i_active_tenants     (r_active_tenants),
        .i_packets_per_wakeup (r_packets_per_wakeup),
        .i_ready              (i_ready),
        .o_valid              (o_valid),
        .o_record_kind        (o_record_kind),
        .o_record_tenant      (o_record_tenant),
        .o_forwarded_count    (o_forwarded_count),
        .o_dropped_count      (o_dropped_count),
        .o_byte_count         (o_byte_count),
        .o_cycle_count        (o_cycle_count),
        .o_last               (o_last)
    );

    // a new transaction only enters with nothing left to emit
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !(w_stat.pend_chg || w_stat.pend_cons
                                   || w_stat.pend_batch || w_stat.pend_drain))
        else $error("transaction accepted with records still pending");

    // a record is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> w_stat.out_free)
        else $error("record loaded over an unconsumed record");

    // the final slot of the walk ends the drain
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.scan_step && w_stat.scan_last) |=> !w_stat.pend_drain)
        else $error("drain still pending after the last slot");

endmodule

`default_nettype wire

>>> sv/tsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire tsc_pkg::t_dp_stat i_stat,
    output tsc_pkg::t_dp_cmd       o_ctl
);
    import tsc_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_ctl.update = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                // records go out in order: tenant change, consumption, batch, drain
                priority if (i_stat.pend_chg) begin
                    o_ctl.sel  = SEL_CHG;
                    o_ctl.emit = i_stat.out_free;
                end else if (i_stat.pend_cons) begin
                    o_ctl.sel  = SEL_CONS;
                    o_ctl.emit = i_stat.out_free;
                end else if (i_stat.pend_batch) begin
                    o_ctl.sel  = SEL_BATCH;
                    o_ctl.emit = i_stat.out_free;
                end else if (i_stat.pend_drain) begin
                    // slots with nothing to flush are cleared without waiting on the output
                    o_ctl.sel       = SEL_DRAIN;
                    o_ctl.emit      = i_stat.cur_flush & i_stat.out_free;
                    o_ctl.scan_step = !i_stat.cur_flush | i_stat.out_free;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/tsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_datapath #(
    parameter int QUEUES = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tsc_pkg::t_dp_cmd              i_ctl,
    output tsc_pkg::t_dp_stat                  o_stat,
    input  wire logic                          i_cmd,
    input  wire logic [tsc_pkg::QUEUE_W-1:0]   i_queue,
    input  wire logic [tsc_pkg::TENANT_W-1:0]  i_tenant,
    input  wire logic                          i_was_forwarded,
    input  wire logic [tsc_pkg::LEN_W-1:0]     i_packet_length,
    input  wire logic [tsc_pkg::CYC_W-1:0]     i_cycles_spent,
    input  wire logic [tsc_pkg::ACT_W-1:0]     i_active_tenants,
    input  wire logic [tsc_pkg::PPW_W-1:0]     i_packets_per_wakeup,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic                               o_record_kind,
    output logic [tsc_pkg::TENANT_W-1:0]       o_record_tenant,
    output logic [tsc_pkg::CNT_W-1:0]          o_forwarded_count,
    output logic [tsc_pkg::CNT_W-1:0]          o_dropped_count,
    output logic [tsc_pkg::BYTES_W-1:0]        o_byte_count,
    output logic [tsc_pkg::CYC_W-1:0]          o_cycle_count,
    output logic                               o_last
);
    import tsc_pkg::*;

    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    // captured transaction
    logic                    r_cmd;
    logic [QUEUE_W-1:0]      r_queue;
    logic [TENANT_W-1:0]     r_tenant;
    logic                    r_fwd;
    logic [LEN_W-1:0]        r_len;
    logic [CYC_W-1:0]        r_cyc;

    // per-queue coalescing slots
    logic [TENANT_W-1:0]     r_slot_tenant [QUEUES];
    logic                    r_slot_valid  [QUEUES];
    logic [CNT_W-1:0]        r_slot_fwd    [QUEUES];
    logic [CNT_W-1:0]        r_slot_drop   [QUEUES];
    logic [SLOT_BYTES_W-1:0] r_slot_bytes  [QUEUES];

    // staged flush records
    logic [TENANT_W-1:0]     r_chg_tenant;
    logic [CNT_W-1:0]        r_chg_fwd;
    logic [CNT_W-1:0]        r_chg_drop;
    logic [SLOT_BYTES_W-1:0] r_chg_bytes;
    logic [CNT_W-1:0]        r_bat_fwd;
    logic [CNT_W-1:0]        r_bat_drop;
    logic [SLOT_BYTES_W-1:0] r_bat_bytes;

    logic                    r_chg;
    logic                    r_cons;
    logic                    r_batch;
    logic                    r_drain;
    logic [PPW_W-1:0]        r_psw;
    logic [QW-1:0]           r_scan;

    logic                    r_out_valid;
    logic                    r_out_kind;
    logic [TENANT_W-1:0]     r_out_tenant;
    logic [CNT_W-1:0]        r_out_fwd;
    logic [CNT_W-1:0]        r_out_drop;
    logic [BYTES_W-1:0]      r_out_bytes;
    logic [CYC_W-1:0]        r_out_cyc;
    logic                    r_out_last;

    logic [QW-1:0]           addr;
    logic [QUEUES-1:0]       flushable;
    logic                    later_flush;
    logic                    drain_any;
    logic                    scan_last;
    logic                    out_free;
    logic                    do_update;
    logic                    in_range;
    logic                    change;
    logic                    chg_flush;
    logic                    batch;
    logic                    drain_due;
    logic [TENANT_W-1:0]     old_tenant;
    logic                    old_valid;
    logic [CNT_W-1:0]        old_fwd;
    logic [CNT_W-1:0]        old_drop;
    logic [SLOT_BYTES_W-1:0] old_bytes;
    logic [CNT_W-1:0]        base_fwd;
    logic [CNT_W-1:0]        base_drop;
    logic [SLOT_BYTES_W-1:0] base_bytes;
    logic [CNT_W-1:0]        new_fwd;
    logic [CNT_W-1:0]        new_drop;
    logic [SLOT_BYTES_W-1:0] new_bytes;
    logic [PPW_W-1:0]        psw_inc;

    // one slot port: the packet's queue during update, the scan pointer otherwise
    assign addr       = i_ctl.update ? QW'(r_queue) : r_scan;
    assign old_tenant = r_slot_tenant[addr];
    assign old_valid  = r_slot_valid[addr];
    assign old_fwd    = r_slot_fwd[addr];
    assign old_drop   = r_slot_drop[addr];
    assign old_bytes  = r_slot_bytes[addr];

    always_comb begin
        later_flush = 1'b0;
        for (int i = 0; i < QUEUES; i++) begin
            flushable[i] = r_slot_valid[i]
                && ({1'b0, r_slot_tenant[i]} < i_active_tenants)
                && ((r_slot_fwd[i] != '0) || (r_slot_drop[i] != '0));
            if (flushable[i] && (QW'(i) > r_scan)) begin
                later_flush = 1'b1;
            end
        end
    end

    assign drain_any = r_drain && (|flushable);
    assign scan_last = (r_scan == QW'(QUEUES - 1));
    assign out_free  = !r_out_valid || i_ready;

    assign do_update  = i_ctl.update && (r_cmd != CMD_DRAIN);
    assign in_range   = (int'(r_queue) < QUEUES) && ({1'b0, r_tenant} < i_active_tenants);
    assign change     = !old_valid || (old_tenant != r_tenant);
    assign chg_flush  = change && flushable[addr];
    assign base_fwd   = change ? '0 : old_fwd;
    assign base_drop  = change ? '0 : old_drop;
    assign base_bytes = change ? '0 : old_bytes;
    assign new_fwd    = base_fwd + CNT_W'(r_fwd);
    assign new_drop   = base_drop + CNT_W'(!r_fwd);
    assign new_bytes  = r_fwd ? (base_bytes + SLOT_BYTES_W'(r_len)) : base_bytes;
    assign batch      = ((8'(new_fwd) + 8'(new_drop)) >= 8'(FLUSH_BATCH));
    assign psw_inc    = r_psw + PPW_W'(1);
    assign drain_due  = (psw_inc >= i_packets_per_wakeup);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd    <= i_cmd;
            r_queue  <= i_queue;
            r_tenant <= i_tenant;
            r_fwd    <= i_was_forwarded;
            r_len    <= i_packet_length;
            r_cyc    <= i_cycles_spent;
        end
        if (do_update) begin
            r_chg_tenant <= old_tenant;
            r_chg_fwd    <= old_fwd;
            r_chg_drop   <= old_drop;
            r_chg_bytes  <= old_bytes;
            r_bat_fwd    <= new_fwd;
            r_bat_drop   <= new_drop;
            r_bat_bytes  <= new_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_slot_tenant[i] <= '0;
                r_slot_valid[i]  <= 1'b0;
                r_slot_fwd[i]    <= '0;
                r_slot_drop[i]   <= '0;
                r_slot_bytes[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < QUEUES; i++) begin
                if (do_update && in_range && (QW'(i) == addr)) begin
                    r_slot_tenant[i] <= r_tenant;
                    r_slot_valid[i]  <= 1'b1;
                    r_slot_fwd[i]    <= batch ? '0 : new_fwd;
                    r_slot_drop[i]   <= batch ? '0 : new_drop;
                    r_slot_bytes[i]  <= batch ? '0 : new_bytes;
                end else if (i_ctl.scan_step && (QW'(i) == addr)) begin
                    r_slot_tenant[i] <= '0;
                    r_slot_valid[i]  <= 1'b0;
                    r_slot_fwd[i]    <= '0;
                    r_slot_drop[i]   <= '0;
                    r_slot_bytes[i]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg   <= 1'b0;
            r_cons  <= 1'b0;
            r_batch <= 1'b0;
            r_drain <= 1'b0;
            r_psw   <= '0;
            r_scan  <= '0;
        end else begin
            if (i_ctl.capture) begin
                r_drain <= (i_cmd == CMD_DRAIN);
            end
            if (do_update) begin
                r_chg   <= in_range && chg_flush;
                r_cons  <= in_range && r_fwd;
                r_batch <= in_range && batch;
                r_psw   <= psw_inc;
                r_drain <= drain_due;
            end
            if (i_ctl.emit) begin
                unique case (i_ctl.sel)
                    SEL_CHG:   r_chg   <= 1'b0;
                    SEL_CONS:  r_cons  <= 1'b0;
                    SEL_BATCH: r_batch <= 1'b0;
                    SEL_DRAIN: ;
                endcase
            end
            if (i_ctl.scan_step) begin
                if (scan_last) begin
                    r_scan  <= '0;
                    r_drain <= 1'b0;
                    r_psw   <= '0;
                end else begin
                    r_scan <= r_scan + QW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            unique case (i_ctl.sel)
                SEL_CHG: begin
                    r_out_kind   <= KIND_FLUSH;
                    r_out_tenant <= r_chg_tenant;
                    r_out_fwd    <= r_chg_fwd;
                    r_out_drop   <= r_chg_drop;
                    r_out_bytes  <= r_chg_bytes[BYTES_W-1:0];
                    r_out_cyc    <= '0;
                    r_out_last   <= !(r_cons || r_batch || drain_any);
                end
                SEL_CONS: begin
                    r_out_kind   <= KIND_CONSUME;
                    r_out_tenant <= r_tenant;
                    r_out_fwd    <= '0;
                    r_out_drop   <= '0;
                    r_out_bytes  <= BYTES_W'(r_len);
                    r_out_cyc    <= r_cyc;
                    r_out_last   <= !(r_batch || drain_any);
                end
                SEL_BATCH: begin
                    r_out_kind   <= KIND_FLUSH;
                    r_out_tenant <= r_tenant;
                    r_out_fwd    <= r_bat_fwd;
                    r_out_drop   <= r_bat_drop;
                    r_out_bytes  <= r_bat_bytes[BYTES_W-1:0];
                    r_out_cyc    <= '0;
                    r_out_last   <= !drain_any;
                end
                SEL_DRAIN: begin
                    r_out_kind   <= KIND_FLUSH;
                    r_out_tenant <= old_tenant;
                    r_out_fwd    <= old_fwd;
                    r_out_drop   <= old_drop;
                    r_out_bytes  <= old_bytes[BYTES_W-1:0];
                    r_out_cyc    <= '0;
                    r_out_last   <= !later_flush;
                end
            endcase
        end
    end

    assign o_stat.pend_chg   = r_chg;
    assign o_stat.pend_cons  = r_cons;
    assign o_stat.pend_batch = r_batch;
    assign o_stat.pend_drain = r_drain;
    assign o_stat.cur_flush  = flushable[r_scan];
    assign o_stat.scan_last  = scan_last;
    assign o_stat.out_free   = out_free;

    assign o_valid           = r_out_valid;
    assign o_record_kind     = r_out_kind;
    assign o_record_tenant   = r_out_tenant;
    assign o_forwarded_count = r_out_fwd;
    assign o_dropped_count   = r_out_drop;
    assign o_byte_count      = r_out_bytes;
    assign o_cycle_count     = r_out_cyc;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire
